@@ rtl/stack_machine_executor_macros.svh @@
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// same-cycle implication
`define SME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sme_pkg;

    localparam int STACK_DEPTH_DEF     = 64;
    localparam int MAX_PRINT_WORDS_DEF = 16;
    localparam int WORD_W              = 32;
    localparam int DEPTH_OUT_W         = 7;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_PUSH  = 4'd1,
        OP_POP   = 4'd2,
        OP_PEEK  = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_DIV   = 4'd6,
        OP_MUL   = 4'd7,
        OP_PRINT = 4'd8
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_B,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_PR_TOP,
        ST_PR_INT,
        ST_PR_WORD,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/sme_stack_mem.sv @@
// ----------------------------------------------------------------------------
// sme_stack_mem
// Stack word storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sme_stack_mem #(
    parameter int DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = sme_pkg::WORD_W + 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sme_divider.sv @@
// ----------------------------------------------------------------------------
// sme_divider
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sme_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  sme_pkg::div_req_t  req,
    output sme_pkg::div_rsp_t  rsp
);

    localparam int W  = sme_pkg::WORD_W;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg,  busy_next;
    logic          done_reg,  done_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [W:0]    rem_reg,   rem_next;
    logic [W-1:0]  quo_reg,   quo_next;
    logic [W-1:0]  dvs_reg,   dvs_next;
    logic          neg_reg,   neg_next;

    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;

    assign rem_shift = {rem_reg[W-1:0], quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            quo_next  = req.dividend[W-1] ? (~req.dividend + W'(1)) : req.dividend;
            dvs_next  = req.divisor[W-1] ? (~req.divisor + W'(1)) : req.divisor;
            neg_next  = req.dividend[W-1] ^ req.divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!rem_diff[W])
            begin
                rem_next = rem_diff;
            end
            else
            begin
                rem_next = rem_shift;
            end
            quo_next = {quo_reg[W-2:0], ~rem_diff[W]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

@@ rtl/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack instruction per input transfer on a stack of typed words.
// ----------------------------------------------------------------------------
// One instruction is taken at a time; s_tready is high only between
// instructions. Every instruction ends with a status transfer (tlast high);
// PRINT adds printed words before it. NOP, PEEK, PUSH, POP, unknown codes,
// stack underflow or overflow and any halted instruction go from decode
// straight to the status transfer; ADD, SUB and MUL make two stack reads
// through the registered memory port, execute and write back; DIV runs the
// 32-step shift-subtract divider and then picks up its result, or halts on a
// zero divisor; PRINT pops an integer top, or for text steps through the
// words it pops.
// A full output register stalls the sequencer until it is taken.
`timescale 1ns / 1ps

`include "stack_machine_executor_macros.svh"

module stack_machine_executor #(
    parameter int STACK_DEPTH     = sme_pkg::STACK_DEPTH_DEF,
    parameter int MAX_PRINT_WORDS = sme_pkg::MAX_PRINT_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [4:0]  s_tuser,   // [3:0] operation, [4] operand_is_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] word_value, [32] halted, [39:33] stack_depth
    output logic [1:0]  m_tuser,   // [0] word_is_text, [1] is_printed
    output logic        m_tlast
);

    localparam int W    = sme_pkg::WORD_W;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int CW   = $clog2(MAX_PRINT_WORDS + 1);
    localparam int DOW  = sme_pkg::DEPTH_OUT_W;
    localparam logic signed [W-1:0] PRINT_LIM = W'(MAX_PRINT_WORDS + 1);

    sme_pkg::state_t     state_reg, state_next;
    sme_pkg::op_t        op_reg,    op_next;
    logic [W-1:0]        opv_reg,   opv_next;
    logic                optext_reg, optext_next;
    logic [SP_W-1:0]     sp_reg,    sp_next;
    logic                halt_reg,  halt_next;
    logic [W-1:0]        a_reg,     a_next;
    logic [W-1:0]        c_reg,     c_next;
    logic [CW-1:0]       cnt_reg,   cnt_next;
    logic [AW-1:0]       rptr_reg,  rptr_next;

    logic                out_valid_reg,   out_valid_next;
    logic [W-1:0]        out_word_reg,    out_word_next;
    logic                out_text_reg,    out_text_next;
    logic                out_printed_reg, out_printed_next;
    logic                out_halted_reg,  out_halted_next;
    logic [DOW-1:0]      out_depth_reg,   out_depth_next;
    logic                out_last_reg,    out_last_next;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [W:0]          mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [W:0]          mem_rd_data;

    sme_pkg::div_req_t   div_req;
    sme_pkg::div_rsp_t   div_rsp;

    logic                out_free;
    logic [W-1:0]        sp_ext;
    logic [W-1:0]        sp_next_ext;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic [W-1:0]        opv_m1;
    logic [CW-1:0]       cnt_sat;
    logic [W-1:0]        cnt_ext;
    logic [W-1:0]        product;
    logic                word_step;

    sme_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .DW    (W + 1)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sme_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign sp_ext      = {{(W-SP_W){1'b0}}, sp_reg};
    assign sp_next_ext = {{(W-SP_W){1'b0}}, sp_next};
    assign sp_m1       = sp_reg - SP_W'(1);
    assign sp_m2       = sp_reg - SP_W'(2);
    assign opv_m1      = opv_reg - W'(1);
    assign cnt_ext     = {{(W-CW){1'b0}}, cnt_sat};
    assign product     = mem_rd_data[W-1:0] * a_reg;
    assign word_step   = !mem_rd_data[W] || out_free;

    always_comb
    begin
        if ($signed(opv_reg) <= $signed(W'(1)))
        begin
            cnt_sat = '0;
        end
        else if ($signed(opv_reg) > PRINT_LIM)
        begin
            cnt_sat = CW'(MAX_PRINT_WORDS);
        end
        else
        begin
            cnt_sat = opv_m1[CW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sme_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sme_pkg::ST_DECODE;
                end
            end
            sme_pkg::ST_DECODE:
            begin
                state_next = sme_pkg::ST_STATUS;
                if (!halt_reg)
                begin
                    unique case (op_reg)
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_DIV, sme_pkg::OP_MUL:
                        begin
                            if (sp_ext >= W'(2))
                            begin
                                state_next = sme_pkg::ST_RD_B;
                            end
                        end
                        sme_pkg::OP_PRINT:
                        begin
                            if (sp_reg != '0)
                            begin
                                state_next = sme_pkg::ST_PR_TOP;
                            end
                        end
                        default:
                        begin
                            state_next = sme_pkg::ST_STATUS;
                        end
                    endcase
                end
            end
            sme_pkg::ST_RD_B:
            begin
                state_next = sme_pkg::ST_EXEC;
            end
            sme_pkg::ST_EXEC:
            begin
                if (op_reg == sme_pkg::OP_DIV)
                begin
                    state_next = (a_reg == '0) ? sme_pkg::ST_STATUS : sme_pkg::ST_DIV;
                end
                else
                begin
                    state_next = sme_pkg::ST_WB;
                end
            end
            sme_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = sme_pkg::ST_WB;
                end
            end
            sme_pkg::ST_WB:
            begin
                state_next = sme_pkg::ST_STATUS;
            end
            sme_pkg::ST_PR_TOP:
            begin
                if (!mem_rd_data[W])
                begin
                    state_next = sme_pkg::ST_PR_INT;
                end
                else if (cnt_ext > sp_ext || cnt_sat == '0)
                begin
                    state_next = sme_pkg::ST_STATUS;
                end
                else
                begin
                    state_next = sme_pkg::ST_PR_WORD;
                end
            end
            sme_pkg::ST_PR_INT:
            begin
                if (out_free)
                begin
                    state_next = sme_pkg::ST_STATUS;
                end
            end
            sme_pkg::ST_PR_WORD:
            begin
                if (word_step && cnt_reg == CW'(1))
                begin
                    state_next = sme_pkg::ST_STATUS;
                end
            end
            sme_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = sme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sme_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next          = op_reg;
        opv_next         = opv_reg;
        optext_next      = optext_reg;
        sp_next          = sp_reg;
        halt_next        = halt_reg;
        a_next           = a_reg;
        c_next           = c_reg;
        cnt_next         = cnt_reg;
        rptr_next        = rptr_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_word_next    = out_word_reg;
        out_text_next    = out_text_reg;
        out_printed_next = out_printed_reg;
        out_halted_next  = out_halted_reg;
        out_depth_next   = out_depth_reg;
        out_last_next    = out_last_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = sp_reg[AW-1:0];
        mem_wr_data      = {optext_reg, opv_reg};
        mem_rd_en        = 1'b0;
        mem_rd_addr      = sp_m1[AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = mem_rd_data[W-1:0];
        div_req.divisor  = a_reg;
        unique case (state_reg)
            sme_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = sme_pkg::op_t'(s_tuser[3:0]);
                    optext_next = s_tuser[4];
                    opv_next    = s_tdata;
                end
            end
            sme_pkg::ST_DECODE:
            begin
                if (!halt_reg)
                begin
                    unique case (op_reg)
                        sme_pkg::OP_PUSH:
                        begin
                            if (sp_ext >= W'(STACK_DEPTH))
                            begin
                                halt_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr_en = 1'b1;
                                sp_next   = sp_reg + SP_W'(1);
                            end
                        end
                        sme_pkg::OP_POP:
                        begin
                            if (sp_reg == '0)
                            begin
                                halt_next = 1'b1;
                            end
                            else
                            begin
                                sp_next = sp_m1;
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_DIV, sme_pkg::OP_MUL:
                        begin
                            if (sp_ext < W'(2))
                            begin
                                halt_next = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en = 1'b1;
                            end
                        end
                        sme_pkg::OP_PRINT:
                        begin
                            if (sp_reg == '0)
                            begin
                                halt_next = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            halt_next = halt_reg;
                        end
                    endcase
                end
            end
            sme_pkg::ST_RD_B:
            begin
                a_next      = mem_rd_data[W-1:0];
                mem_rd_en   = 1'b1;
                mem_rd_addr = sp_m2[AW-1:0];
            end
            sme_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    sme_pkg::OP_ADD: c_next = mem_rd_data[W-1:0] + a_reg;
                    sme_pkg::OP_SUB: c_next = mem_rd_data[W-1:0] - a_reg;
                    sme_pkg::OP_MUL: c_next = product;
                    default:
                    begin
                        if (a_reg == '0)
                        begin
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                        end
                    end
                endcase
            end
            sme_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    c_next = div_rsp.quotient;
                end
            end
            sme_pkg::ST_WB:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sp_m2[AW-1:0];
                mem_wr_data = {1'b0, c_reg};
                sp_next     = sp_m1;
            end
            sme_pkg::ST_PR_TOP:
            begin
                if (!mem_rd_data[W])
                begin
                    sp_next = sp_m1;
                    c_next  = mem_rd_data[W-1:0];
                end
                else if (cnt_ext > sp_ext)
                begin
                    halt_next = 1'b1;
                end
                else if (cnt_sat != '0)
                begin
                    sp_next   = sp_reg - SP_W'(cnt_sat);
                    cnt_next  = cnt_sat;
                    rptr_next = sp_m1[AW-1:0];
                end
            end
            sme_pkg::ST_PR_INT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = c_reg;
                    out_text_next    = 1'b0;
                    out_printed_next = 1'b1;
                    out_halted_next  = halt_reg;
                    out_depth_next   = sp_ext[DOW-1:0];
                    out_last_next    = 1'b0;
                end
            end
            sme_pkg::ST_PR_WORD:
            begin
                if (mem_rd_data[W] && out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = mem_rd_data[W-1:0];
                    out_text_next    = 1'b1;
                    out_printed_next = 1'b1;
                    out_halted_next  = halt_reg;
                    out_depth_next   = sp_ext[DOW-1:0];
                    out_last_next    = 1'b0;
                end
                if (word_step)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg != CW'(1))
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = rptr_reg - AW'(1);
                        rptr_next   = rptr_reg - AW'(1);
                    end
                end
            end
            sme_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = '0;
                    out_text_next    = 1'b0;
                    out_printed_next = 1'b0;
                    out_halted_next  = halt_reg;
                    out_depth_next   = sp_ext[DOW-1:0];
                    out_last_next    = 1'b1;
                end
            end
            default:
            begin
                halt_next = halt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sme_pkg::ST_IDLE;
            sp_reg        <= '0;
            halt_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halt_reg      <= halt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        opv_reg         <= opv_next;
        optext_reg      <= optext_next;
        a_reg           <= a_next;
        c_reg           <= c_next;
        rptr_reg        <= rptr_next;
        out_word_reg    <= out_word_next;
        out_text_reg    <= out_text_next;
        out_printed_reg <= out_printed_next;
        out_halted_reg  <= out_halted_next;
        out_depth_reg   <= out_depth_next;
        out_last_reg    <= out_last_next;
    end

    assign s_tready = (state_reg == sme_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_depth_reg, out_halted_reg, out_word_reg};
    assign m_tuser  = {out_printed_reg, out_text_reg};
    assign m_tlast  = out_last_reg;

    `SME_ASSERT_NXT(a_halt_sticky, halt_reg, halt_reg, "halt flag dropped")
    `SME_ASSERT_IMP(a_sp_bound, 1'b1, sp_next_ext <= W'(STACK_DEPTH), "stack pointer past depth")
    `SME_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transfer taken")
    `SME_ASSERT_IMP(a_div_nonzero, div_req.start, a_reg != '0, "divider started on zero")

endmodule

@@ tb/stack_machine_executor_test.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor_test
// Drives instruction transfers into the stack machine and checks every output
// transfer against a shadow stack kept in the testbench. A short table of
// directed instructions comes first, then well-formed random programs with
// some noise. The run ends by forcing one randomly chosen halt cause, after
// which further instructions must be ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_executor_test;
    import sme_pkg::*;

    localparam int          STACK_WORDS  = STACK_DEPTH_DEF;
    localparam int          PRINT_MAX    = MAX_PRINT_WORDS_DEF;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          N_DIRECTED   = 26;
    localparam int          PRESSURE_AT  = 150;
    localparam int          PRESSURE_CYC = 400;
    localparam int          DRAIN_LIMIT  = 200000;
    localparam int          SETTLE_CYC   = 60;
    localparam logic [3:0]  OP_CODE_MAX  = 4'hF;
    localparam logic [31:0] INT_MIN_W    = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_W    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] word_value;
        logic        word_is_text;
        logic        is_printed;
        logic        halted;
        logic [6:0]  stack_depth;
        logic        last;
    } exec_out_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] operand;
        logic        text;
        logic        typed;
        logic        prints;
        logic [31:0] printed_word;
        logic [6:0]  depth;
    } dir_row_t;

    typedef enum int {
        HALT_POP_EMPTY,
        HALT_ARITH_SHORT,
        HALT_PRINT_EMPTY,
        HALT_TEXT_SHORT,
        HALT_PUSH_FULL,
        HALT_DIV_ZERO
    } halt_cause_e;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [4:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // shadow machine
    logic [32:0] shadow_stack [STACK_WORDS];
    int          shadow_depth   = 0;
    logic        machine_halted = 1'b0;

    exec_out_t   step_out[$];
    exec_out_t   typed_outs[$];
    exec_out_t   due_outputs[$];

    int          n_instr       = 0;
    int          n_transfers   = 0;
    int          n_printed     = 0;
    int          n_errors      = 0;
    int          max_depth     = 0;
    int          calm_items    = 0;
    logic        pressure_done = 1'b0;
    halt_cause_e halt_cause;

    // op, operand, text, typed, prints, printed_word, depth
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{OP_NOP,      32'd0,         1'b0, 1'b1, 1'b0, 32'd0,         7'd0},
        '{OP_PEEK,     32'd0,         1'b0, 1'b1, 1'b0, 32'd0,         7'd0},
        '{OP_CODE_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'd0,         7'd0},
        '{OP_PUSH,     INT_MAX_W,     1'b0, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PUSH,     INT_MIN_W,     1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_ADD,      32'd0,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_PRINT,    32'd0,         1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 7'd0},
        '{OP_PUSH,     INT_MIN_W,     1'b0, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PUSH,     32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_DIV,      32'd0,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_PRINT,    32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, INT_MIN_W,     7'd0},
        '{OP_PUSH,     32'd7,         1'b0, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PUSH,     32'hFFFF_FFFE, 1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_DIV,      32'd0,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_PUSH,     32'd5,         1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_SUB,      32'd0,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_PUSH,     INT_MAX_W,     1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_MUL,      32'd0,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_POP,      32'd0,         1'b0, 1'b1, 1'b0, 32'd0,         7'd0},
        '{OP_PUSH,     32'h4142_4344, 1'b1, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PUSH,     32'd3,         1'b0, 1'b1, 1'b0, 32'd0,         7'd2},
        '{OP_PUSH,     32'h6162_6364, 1'b1, 1'b1, 1'b0, 32'd0,         7'd3},
        '{OP_PRINT,    32'd4,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0},
        '{OP_PUSH,     32'd0,         1'b1, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PRINT,    INT_MIN_W,     1'b0, 1'b1, 1'b0, 32'd0,         7'd1},
        '{OP_PRINT,    32'd2,         1'b0, 1'b0, 1'b0, 32'd0,         7'd0}
    };

    stack_machine_executor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void add_step_out(logic [31:0] val, logic txt, logic printed,
                                         logic lst);
        exec_out_t r;
        r.word_value   = val;
        r.word_is_text = txt;
        r.is_printed   = printed;
        r.halted       = machine_halted;
        r.stack_depth  = shadow_depth[6:0];
        r.last         = lst;
        step_out.push_back(r);
    endfunction

    function automatic void execute_instr(logic [3:0] op, logic [31:0] opv, logic txt);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [32:0] w;
        logic [32:0] shown[$];
        logic        div_zero;
        longint      sv;
        int          cnt;
        step_out.delete();
        c = '0;
        if (!machine_halted)
        begin
            case (op)
                OP_PUSH:
                begin
                    if (shadow_depth >= STACK_WORDS)
                        machine_halted = 1'b1;
                    else
                    begin
                        shadow_stack[shadow_depth] = {txt, opv};
                        shadow_depth++;
                    end
                end
                OP_POP:
                begin
                    if (shadow_depth == 0)
                        machine_halted = 1'b1;
                    else
                        shadow_depth--;
                end
                OP_ADD, OP_SUB, OP_DIV, OP_MUL:
                begin
                    if (shadow_depth < 2)
                        machine_halted = 1'b1;
                    else
                    begin
                        a = shadow_stack[shadow_depth - 1][31:0];
                        b = shadow_stack[shadow_depth - 2][31:0];
                        div_zero = 1'b0;
                        case (op)
                            OP_ADD: c = b + a;
                            OP_SUB: c = b - a;
                            OP_MUL: c = b * a;
                            default:
                            begin
                                if (a == '0)
                                    div_zero = 1'b1;
                                else if (b == INT_MIN_W && a == '1)
                                    c = INT_MIN_W;
                                else
                                    c = $signed(b) / $signed(a);
                            end
                        endcase
                        if (div_zero)
                            machine_halted = 1'b1;
                        else
                        begin
                            shadow_depth -= 2;
                            shadow_stack[shadow_depth] = {1'b0, c};
                            shadow_depth++;
                        end
                    end
                end
                OP_PRINT:
                begin
                    if (shadow_depth == 0)
                        machine_halted = 1'b1;
                    else if (!shadow_stack[shadow_depth - 1][32])
                    begin
                        shadow_depth--;
                        shown.push_back(shadow_stack[shadow_depth]);
                    end
                    else
                    begin
                        sv = $signed(opv);
                        if (sv <= 1)
                            cnt = 0;
                        else if (sv - 1 > PRINT_MAX)
                            cnt = PRINT_MAX;
                        else
                            cnt = int'(sv - 1);
                        if (cnt > shadow_depth)
                            machine_halted = 1'b1;
                        else
                        begin
                            repeat (cnt)
                            begin
                                shadow_depth--;
                                w = shadow_stack[shadow_depth];
                                if (w[32])
                                    shown.push_back(w);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (shadow_depth > max_depth)
            max_depth = shadow_depth;
        foreach (shown[i])
            add_step_out(shown[i][31:0], shown[i][32], 1'b1, 1'b0);
        add_step_out(32'd0, 1'b0, 1'b0, 1'b1);
    endfunction

    // mostly short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return INT_MIN_W;
            1: return INT_MAX_W;
            2: return '1;
            3: return '0;
            4, 5: return $urandom_range(0, 40);
            6: return 32'(-int'($urandom_range(1, 40)));
            default: return $urandom;
        endcase
    endfunction

    // operand for a text print that never pops more than the stack holds
    function automatic logic [31:0] print_operand();
        int hi;
        int cnt;
        hi  = (shadow_depth < PRINT_MAX) ? shadow_depth : PRINT_MAX;
        cnt = $urandom_range(0, hi);
        if (cnt == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'd0;
                1: return 32'd1;
                2: return INT_MIN_W;
                default: return INT_MIN_W | $urandom;
            endcase
        end
        if (cnt == PRINT_MAX && $urandom_range(0, 1) == 1)
            return $urandom_range(PRINT_MAX + 2, INT_MAX_W);
        return cnt + 1;
    endfunction

    task automatic send_instr(logic [3:0] op, logic [31:0] opv, logic txt);
        int gap;
        if (calm_items > 0)
        begin
            calm_items--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                calm_items = $urandom_range(10, 40);
            gap = idle_len();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= opv;
        s_tuser  <= {txt, op};
        do
            @(posedge clk);
        while (!s_tready);
        execute_instr(op, opv, txt);
        if (typed_outs.size() != 0)
        begin
            foreach (typed_outs[i])
                due_outputs.push_back(typed_outs[i]);
            typed_outs.delete();
        end
        else
        begin
            foreach (step_out[i])
                due_outputs.push_back(step_out[i]);
        end
        n_instr++;
    endtask

    task automatic issue_random();
        int          r;
        int          push_pct;
        logic [3:0]  op;
        logic [31:0] opv;
        logic        txt;
        r        = $urandom_range(0, 99);
        opv      = $urandom;
        txt      = 1'b0;
        push_pct = (shadow_depth < 4) ? 65 : ((shadow_depth > 48) ? 10 : 35);
        if (r < 8)
        begin
            case ($urandom_range(0, 2))
                0: op = OP_NOP;
                1: op = OP_PEEK;
                default: op = 4'($urandom_range(OP_PRINT + 1, OP_CODE_MAX));
            endcase
            txt = $urandom_range(0, 1);
        end
        else if (shadow_depth == 0 || (r < 8 + push_pct && shadow_depth < STACK_WORDS))
        begin
            op  = OP_PUSH;
            opv = rand_word();
            txt = ($urandom_range(0, 2) == 0);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1: op = OP_POP;
                2, 3: op = OP_PRINT;
                4, 5: op = OP_ADD;
                6: op = OP_SUB;
                7: op = OP_MUL;
                default: op = OP_DIV;
            endcase
            if (shadow_depth < 2 && op != OP_PRINT)
                op = OP_POP;
            if (op == OP_DIV && shadow_stack[shadow_depth - 1][31:0] == '0)
                op = OP_SUB;
            if (op == OP_PRINT && shadow_stack[shadow_depth - 1][32])
                opv = print_operand();
        end
        send_instr(op, opv, txt);
    endtask

    task automatic issue_text_run();
        int room;
        int n;
        room = STACK_WORDS - shadow_depth;
        n    = $urandom_range(1, (room < 20) ? room : 20);
        repeat (n) send_instr(OP_PUSH, rand_word(), $urandom_range(0, 4) != 0);
        send_instr(OP_PRINT, print_operand(), 1'b0);
    endtask

    task automatic provoke_halt();
        halt_cause = halt_cause_e'($urandom_range(HALT_POP_EMPTY, HALT_DIV_ZERO));
        if (halt_cause != HALT_PUSH_FULL)
        begin
            while (shadow_depth > 0)
                send_instr(OP_POP, $urandom, 1'b0);
        end
        case (halt_cause)
            HALT_POP_EMPTY:
                send_instr(OP_POP, $urandom, 1'b0);
            HALT_ARITH_SHORT:
            begin
                send_instr(OP_PUSH, rand_word(), 1'b0);
                send_instr(4'($urandom_range(OP_ADD, OP_MUL)), $urandom, 1'b0);
            end
            HALT_PRINT_EMPTY:
                send_instr(OP_PRINT, $urandom, 1'b0);
            HALT_TEXT_SHORT:
            begin
                send_instr(OP_PUSH, $urandom, 1'b1);
                send_instr(OP_PRINT, 32'd3, 1'b0);
            end
            HALT_PUSH_FULL:
            begin
                while (shadow_depth < STACK_WORDS)
                    send_instr(OP_PUSH, rand_word(), $urandom_range(0, 1));
                send_instr(OP_PUSH, $urandom, 1'b0);
            end
            default:
            begin
                send_instr(OP_PUSH, rand_word(), 1'b0);
                send_instr(OP_PUSH, 32'd0, 1'b0);
                send_instr(OP_DIV, $urandom, 1'b0);
            end
        endcase
        // everything from here on must be ignored
        repeat (6) send_instr(4'($urandom_range(0, OP_CODE_MAX)), $urandom,
                              $urandom_range(0, 1));
    endtask

    always @(posedge clk)
    begin
        exec_out_t got;
        exec_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.word_value   = m_tdata[31:0];
            got.halted       = m_tdata[32];
            got.stack_depth  = m_tdata[39:33];
            got.word_is_text = m_tuser[0];
            got.is_printed   = m_tuser[1];
            got.last         = m_tlast;
            n_transfers++;
            if (got.is_printed === 1'b1)
                n_printed++;
            if (due_outputs.size() == 0)
            begin
                $error("output transfer with no result pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                n_errors++;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (got.word_value !== want.word_value)
                begin
                    $error("word_value: expected %h, got %h", want.word_value,
                           got.word_value);
                    n_errors++;
                end
                if (got.word_is_text !== want.word_is_text)
                begin
                    $error("word_is_text: expected %b, got %b", want.word_is_text,
                           got.word_is_text);
                    n_errors++;
                end
                if (got.is_printed !== want.is_printed)
                begin
                    $error("is_printed: expected %b, got %b", want.is_printed,
                           got.is_printed);
                    n_errors++;
                end
                if (got.halted !== want.halted)
                begin
                    $error("halted: expected %b, got %b", want.halted, got.halted);
                    n_errors++;
                end
                if (got.stack_depth !== want.stack_depth)
                begin
                    $error("stack_depth: expected %0d, got %0d", want.stack_depth,
                           got.stack_depth);
                    n_errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, got.last);
                    n_errors++;
                end
            end
        end
    end

    // output side: random stalls, one long hold-off while input keeps coming
    initial
    begin
        int run;
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!pressure_done && n_instr >= PRESSURE_AT)
            begin
                m_tready <= 1'b0;
                repeat (PRESSURE_CYC) @(posedge clk);
                pressure_done = 1'b1;
            end
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].prints)
                    typed_outs.push_back('{directed_rows[i].printed_word, 1'b0, 1'b1,
                                           1'b0, directed_rows[i].depth, 1'b0});
                typed_outs.push_back('{32'd0, 1'b0, 1'b0, 1'b0,
                                       directed_rows[i].depth, 1'b1});
            end
            send_instr(directed_rows[i].op, directed_rows[i].operand,
                       directed_rows[i].text);
        end

        while (n_instr < N_DIRECTED + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 6 && shadow_depth < STACK_WORDS)
                issue_text_run();
            else
                issue_random();
        end

        provoke_halt();
        s_tvalid <= 1'b0;

        for (w = 0; w < DRAIN_LIMIT && due_outputs.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (due_outputs.size() != 0)
        begin
            $error("%0d expected output transfers never arrived", due_outputs.size());
            n_errors++;
        end

        $display("Ran %0d instructions, peak stack depth %0d, final halt caused by %s.",
                 n_instr, max_depth, halt_cause.name());
        $display("Checked %0d output transfers (%0d printed words), %0d mismatches.",
                 n_transfers, n_printed, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
